[rtl/core/slm_pkg.sv]
// Package for the sorted list merge block: word types, function and status codes.
`timescale 1ns / 1ps

package slm_pkg;

    localparam int LIST_DEPTH_DEF = 16;
    localparam int VALUE_W        = 32;

    localparam logic [1:0] FUNC_PUSH_A = 2'd0;
    localparam logic [1:0] FUNC_PUSH_B = 2'd1;
    localparam logic [1:0] FUNC_MERGE  = 2'd2;

    localparam logic [1:0] STATUS_DATA  = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]                func;
        logic signed [VALUE_W-1:0] value;
    } cmd_word_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value_res;
        logic                      source;
        logic                      last;
        logic [1:0]                status;
    } res_word_t;

endpackage

[rtl/core/sorted_list_merge.sv]
// Top level of the two-way sorted list merge: two list stores and the merge sequencer.
// Push: no result; a push to a full list gives one status word.
// Merge: each emitted word takes a store read, then a head compare, as the list stores
//   have a registered read; the first word follows the ST_READ and ST_CMP states.
// A merge occupies the block until its last word is emitted; no new word is taken meanwhile.
// Reset (rst_n low, asynchronous) empties both lists; store contents are not cleared.
`timescale 1ns / 1ps

module sorted_list_merge
    import slm_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_word_t cmd,
    output logic      res_valid,
    input  logic      res_stall,
    output res_word_t res
);

    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);

    logic                      wr_a_en;
    logic                      wr_b_en;
    logic [IDX_W-1:0]          wr_a_addr;
    logic [IDX_W-1:0]          wr_b_addr;
    logic [IDX_W-1:0]          rd_a_addr;
    logic [IDX_W-1:0]          rd_b_addr;
    logic signed [VALUE_W-1:0] rd_a_data;
    logic signed [VALUE_W-1:0] rd_b_data;

    slm_list_mem #(
        .LIST_DEPTH (LIST_DEPTH),
        .IDX_W      (IDX_W)
    ) u_list_a (
        .clk     (clk),
        .wr_en   (wr_a_en),
        .wr_addr (wr_a_addr),
        .wr_data (cmd.value),
        .rd_addr (rd_a_addr),
        .rd_data (rd_a_data)
    );

    slm_list_mem #(
        .LIST_DEPTH (LIST_DEPTH),
        .IDX_W      (IDX_W)
    ) u_list_b (
        .clk     (clk),
        .wr_en   (wr_b_en),
        .wr_addr (wr_b_addr),
        .wr_data (cmd.value),
        .rd_addr (rd_b_addr),
        .rd_data (rd_b_data)
    );

    slm_ctrl #(
        .LIST_DEPTH (LIST_DEPTH),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .wr_a_en   (wr_a_en),
        .wr_b_en   (wr_b_en),
        .wr_a_addr (wr_a_addr),
        .wr_b_addr (wr_b_addr),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (rd_b_addr),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data)
    );

endmodule

[rtl/core/slm_list_mem.sv]
// One list store: single write port, single registered read port.
`timescale 1ns / 1ps

module slm_list_mem
    import slm_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF,
    parameter int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1
)
(
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [IDX_W-1:0]          wr_addr,
    input  logic signed [VALUE_W-1:0] wr_data,
    input  logic [IDX_W-1:0]          rd_addr,
    output logic signed [VALUE_W-1:0] rd_data
);

    logic signed [VALUE_W-1:0] mem [LIST_DEPTH];
    logic signed [VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/slm_ctrl.sv]
// Sequencer: list fill counts, merge walk with the shared head compare, result register.
`timescale 1ns / 1ps

module slm_ctrl
    import slm_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF,
    parameter int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1,
    parameter int CNT_W      = $clog2(LIST_DEPTH + 1)
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cmd_valid,
    output logic                      cmd_stall,
    input  cmd_word_t                 cmd,
    output logic                      res_valid,
    input  logic                      res_stall,
    output res_word_t                 res,
    output logic                      wr_a_en,
    output logic                      wr_b_en,
    output logic [IDX_W-1:0]          wr_a_addr,
    output logic [IDX_W-1:0]          wr_b_addr,
    output logic [IDX_W-1:0]          rd_a_addr,
    output logic [IDX_W-1:0]          rd_b_addr,
    input  logic signed [VALUE_W-1:0] rd_a_data,
    input  logic signed [VALUE_W-1:0] rd_b_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP
    } state_t;

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);

    state_t           state_reg,  state_next;
    logic [CNT_W-1:0] cnt_a_reg,  cnt_a_next;
    logic [CNT_W-1:0] cnt_b_reg,  cnt_b_next;
    logic [CNT_W-1:0] i_reg,      i_next;
    logic [CNT_W-1:0] j_reg,      j_next;
    logic             res_valid_reg, res_valid_next;
    res_word_t        res_reg,    res_next;

    logic res_free;
    logic accept;
    logic a_left;
    logic b_left;
    logic take_a;
    logic a_done;
    logic b_done;

    assign res_free  = !res_valid_reg || !res_stall;
    assign cmd_stall = !(state_reg == ST_IDLE && res_free);
    assign accept    = cmd_valid && !cmd_stall;

    assign a_left = i_reg < cnt_a_reg;
    assign b_left = j_reg < cnt_b_reg;
    // shared head compare; tie goes to list A
    assign take_a = a_left && (!b_left || (rd_a_data <= rd_b_data));
    assign a_done = take_a ? ((i_reg + 1'b1) >= cnt_a_reg) : !a_left;
    assign b_done = take_a ? !b_left : ((j_reg + 1'b1) >= cnt_b_reg);

    assign wr_a_en   = accept && cmd.func == FUNC_PUSH_A && cnt_a_reg < DEPTH_C;
    assign wr_b_en   = accept && cmd.func == FUNC_PUSH_B && cnt_b_reg < DEPTH_C;
    assign wr_a_addr = cnt_a_reg[IDX_W-1:0];
    assign wr_b_addr = cnt_b_reg[IDX_W-1:0];
    assign rd_a_addr = i_reg[IDX_W-1:0];
    assign rd_b_addr = j_reg[IDX_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        cnt_a_next     = cnt_a_reg;
        cnt_b_next     = cnt_b_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_next       = res_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.func)
                        FUNC_PUSH_A, FUNC_PUSH_B:
                        begin
                            if (wr_a_en)
                            begin
                                cnt_a_next = cnt_a_reg + 1'b1;
                            end
                            else if (wr_b_en)
                            begin
                                cnt_b_next = cnt_b_reg + 1'b1;
                            end
                            else
                            begin
                                res_valid_next     = 1'b1;
                                res_next.value_res = '0;
                                res_next.source    = cmd.func[0];
                                res_next.last      = 1'b1;
                                res_next.status    = STATUS_FULL;
                            end
                        end
                        FUNC_MERGE:
                        begin
                            if (cnt_a_reg == '0 && cnt_b_reg == '0)
                            begin
                                res_valid_next     = 1'b1;
                                res_next.value_res = '0;
                                res_next.source    = 1'b0;
                                res_next.last      = 1'b1;
                                res_next.status    = STATUS_EMPTY;
                            end
                            else
                            begin
                                i_next     = '0;
                                j_next     = '0;
                                state_next = ST_READ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (res_free)
                begin
                    res_valid_next     = 1'b1;
                    res_next.value_res = take_a ? rd_a_data : rd_b_data;
                    res_next.source    = !take_a;
                    res_next.last      = a_done && b_done;
                    res_next.status    = STATUS_DATA;
                    if (take_a)
                    begin
                        i_next = i_reg + 1'b1;
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                    if (a_done && b_done)
                    begin
                        cnt_a_next = '0;
                        cnt_b_next = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_a_reg     <= '0;
            cnt_b_reg     <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_a_reg     <= cnt_a_next;
            cnt_b_reg     <= cnt_b_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
